// ===== rtl/hbb_pkg.sv =====
// package for the harmonic bandpass biquad bank
// sizes, operation codes, command and status structs, saturation and row address helpers
// no dependencies
`default_nettype none

package hbb_pkg;

	localparam int MAX_HARMONICS = 64;
	localparam int MAX_STAGES    = 5;
	localparam int COEF_WIDTH    = 24;
	localparam int SAMPLE_WIDTH  = 16;

	localparam int FRAC_BITS = COEF_WIDTH - 4;
	localparam int ROWS      = MAX_HARMONICS * MAX_STAGES;
	localparam int CELLS     = ROWS * 4;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int HIST_AW   = ROW_W + 2;
	localparam int HARM_W    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

	// fixed field widths
	localparam int HARM_FW  = 6;
	localparam int STAGE_FW = 3;
	localparam int SEL_FW   = 2;
	localparam int AH_W     = 7;
	localparam int AS_W     = 3;
	localparam int TDATA_W  = 56;

	localparam int ALIGN_SH = FRAC_BITS - (SAMPLE_WIDTH - 1);
	localparam int ALIGN_L  = (ALIGN_SH > 0) ? ALIGN_SH : 0;
	localparam int ALIGN_R  = (ALIGN_SH < 0) ? -ALIGN_SH : 0;

	localparam int PROD_W = 2 * COEF_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam int GR_W   = PROD_W - FRAC_BITS + 1;
	localparam int SUM_W  = GR_W + HARM_W + 1;

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-COEF_WIDTH+1){1'b0}}, {(COEF_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-COEF_WIDTH+1){1'b1}}, {(COEF_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	typedef enum logic [1:0] {
		OP_WR_COEF = 2'd0,
		OP_WR_ROLL = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_PROCESS = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		WS_ZERO,
		WS_X,
		WS_HIST,
		WS_Y
	} wsel_t;

	typedef enum logic [1:0] {
		MS_X,
		MS_HIST,
		MS_GAIN
	} msel_t;

	typedef struct packed {
		logic               rd_en;
		logic [HIST_AW-1:0] rd_addr;
		logic               roll_rd_en;
		logic [HARM_W-1:0]  roll_addr;
		logic               hist_we;
		logic [HIST_AW-1:0] hist_waddr;
		wsel_t              hist_wsel;
		logic               coef_we;
		logic               roll_we;
		logic               mul_en;
		msel_t              mul_sel;
		logic               acc_first;
		logic               acc_en;
		logic               x_load;
		logic               y_load;
		logic               sum_clr;
		logic               sum_en;
		logic               out_load;
		logic               req_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic out_busy;
	} sts_t;

	function automatic logic [ROW_W-1:0] row_of(input logic [HARM_W-1:0] h,
			input logic [STAGE_FW-1:0] s);
		return ROW_W'(h) * ROW_W'(MAX_STAGES) + ROW_W'(s);
	endfunction

	function automatic logic signed [COEF_WIDTH-1:0] sat_coef(
			input logic signed [ACC_W-1:0] v);
		if (v > SAT_HI)
			return SAT_HI[COEF_WIDTH-1:0];
		else if (v < SAT_LO)
			return SAT_LO[COEF_WIDTH-1:0];
		else
			return v[COEF_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hbb_dp.sv =====
// datapath: coefficient, history and rolloff memories, shared multiplier,
// stage accumulator, harmonic sum and output register; uses hbb_pkg
`default_nettype none

module hbb_dp import hbb_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmd_t                         cmd,
	output sts_t                              sts,
	input  wire logic [1:0]                   in_user,
	input  wire logic [TDATA_W-1:0]           in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COEF_WIDTH-1:0]      out_data
);

	logic signed [COEF_WIDTH-1:0] coef_mem [CELLS];
	logic signed [COEF_WIDTH-1:0] hist_mem [CELLS];
	logic signed [COEF_WIDTH-1:0] roll_mem [MAX_HARMONICS];

	op_t                          op_q;
	logic [HARM_FW-1:0]           harm_q;
	logic [STAGE_FW-1:0]          stage_q;
	logic [SEL_FW-1:0]            sel_q;
	logic signed [COEF_WIDTH-1:0] value_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;

	logic signed [COEF_WIDTH-1:0] coef_rd_q, hist_rd_q, roll_rd_q, x_q;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic                         out_valid_q;
	logic signed [COEF_WIDTH-1:0] out_q;

	logic signed [COEF_WIDTH-1:0] x0, y, wdata, mul_a, mul_b;
	logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] x_wide;
	logic signed [ACC_W-1:0]      acc_rnd;
	logic signed [PROD_W-1:0]     gain_rnd;
	logic                         coef_ok, harm_ok;
	logic [HIST_AW-1:0]           coef_waddr;

	always_comb begin
		x_wide   = (SAMPLE_WIDTH+COEF_WIDTH)'(sample_q);
		x_wide   = (x_wide <<< ALIGN_L) >>> ALIGN_R;
		x0       = x_wide[COEF_WIDTH-1:0];
		acc_rnd  = (acc_q + ACC_HALF) >>> FRAC_BITS;
		y        = sat_coef(acc_rnd);
		gain_rnd = (prod_s1 + PROD_HALF) >>> FRAC_BITS;
		harm_ok  = 32'(harm_q) < MAX_HARMONICS;
		coef_ok  = harm_ok && (32'(stage_q) < MAX_STAGES);
		coef_waddr = {row_of(harm_q[HARM_W-1:0], stage_q), sel_q};
		unique case (cmd.hist_wsel)
			WS_X:    wdata = x_q;
			WS_HIST: wdata = hist_rd_q;
			WS_Y:    wdata = y;
			default: wdata = '0;
		endcase
		unique case (cmd.mul_sel)
			MS_X: begin
				mul_a = coef_rd_q;
				mul_b = x_q;
			end
			MS_HIST: begin
				mul_a = coef_rd_q;
				mul_b = hist_rd_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = roll_rd_q;
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.coef_we && coef_ok)
			coef_mem[coef_waddr] <= value_q;
		if (cmd.roll_we && harm_ok)
			roll_mem[harm_q[HARM_W-1:0]] <= value_q;
		if (cmd.hist_we)
			hist_mem[cmd.hist_waddr] <= wdata;
		if (cmd.rd_en) begin
			coef_rd_q <= coef_mem[cmd.rd_addr];
			hist_rd_q <= hist_mem[cmd.rd_addr];
		end
		if (cmd.roll_rd_en)
			roll_rd_q <= roll_mem[cmd.roll_addr];
	end

	// request capture and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q     <= op_t'(in_user);
			harm_q   <= in_data[5:0];
			stage_q  <= in_data[8:6];
			sel_q    <= in_data[10:9];
			value_q  <= in_data[34:11];
			sample_q <= in_data[50:35];
		end
		if (cmd.mul_en)
			prod_s1 <= mul_a * mul_b;
		if (cmd.acc_first)
			acc_q <= ACC_W'(prod_s1);
		else if (cmd.acc_en)
			acc_q <= acc_q + ACC_W'(prod_s1);
		if (cmd.x_load)
			x_q <= x0;
		else if (cmd.y_load)
			x_q <= y;
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (cmd.sum_en)
			sum_q <= sum_q + SUM_W'(signed'(gain_rnd[GR_W-1:0]));
		if (cmd.out_load)
			out_q <= sat_coef(ACC_W'(sum_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.op       = op_q;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

`default_nettype wire

// ===== rtl/hbb_ctrl.sv =====
// controller: request decode, history clearing sweep and the
// harmonic/stage sequencer driving hbb_dp; uses hbb_pkg
`default_nettype none

module hbb_ctrl import hbb_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic            cfg_index,
	input  wire logic [AH_W-1:0] cfg_data,
	input  wire sts_t            sts,
	output cmd_t                 cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_HARM,
		S_STAGE,
		S_GAIN,
		S_OUT
	} state_t;

	localparam logic [HIST_AW-1:0] CLR_LAST = HIST_AW'(CELLS - 1);

	state_t              state_q;
	logic [HARM_W-1:0]   n_q;
	logic [STAGE_FW-1:0] s_q;
	logic [2:0]          ph_q;
	logic [HIST_AW-1:0]  clr_q;
	logic [AH_W-1:0]     ah_q;
	logic [AS_W-1:0]     as_q;

	logic [AH_W-1:0]     nh;
	logic [AS_W-1:0]     ns;
	logic                last_h, last_s;
	logic [ROW_W-1:0]    row;

	always_comb begin
		nh = (32'(ah_q) > MAX_HARMONICS) ? AH_W'(MAX_HARMONICS) : ah_q;
		ns = (32'(as_q) > MAX_STAGES) ? AS_W'(MAX_STAGES) : as_q;
		last_h = (AH_W'(n_q) + AH_W'(1)) == nh;
		last_s = (AS_W'(s_q) + AS_W'(1)) == ns;
		row = row_of(n_q, s_q);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd = '0;
		cmd.hist_wsel = WS_ZERO;
		cmd.mul_sel   = MS_X;
		cmd.roll_addr = n_q;
		cmd.req_load  = in_valid && in_ready;
		unique case (state_q)
			S_CLEAR: begin
				cmd.hist_we    = 1'b1;
				cmd.hist_waddr = clr_q;
			end
			S_DECODE: begin
				cmd.coef_we = (sts.op == OP_WR_COEF);
				cmd.roll_we = (sts.op == OP_WR_ROLL);
				cmd.sum_clr = (sts.op == OP_PROCESS);
			end
			S_HARM: begin
				cmd.x_load     = 1'b1;
				cmd.roll_rd_en = 1'b1;
			end
			S_STAGE: begin
				cmd.rd_en   = (ph_q <= 3'd3);
				cmd.rd_addr = {row, ph_q[1:0]};
				cmd.mul_en  = (ph_q >= 3'd1) && (ph_q <= 3'd4);
				cmd.mul_sel = (ph_q == 3'd1) ? MS_X : MS_HIST;
				cmd.acc_first = (ph_q == 3'd2);
				cmd.acc_en    = (ph_q >= 3'd3) && (ph_q <= 3'd5);
				unique case (ph_q)
					3'd0: begin
						cmd.hist_we    = 1'b1;
						cmd.hist_waddr = {row, 2'd0};
						cmd.hist_wsel  = WS_X;
					end
					3'd1: begin
						cmd.hist_we    = 1'b1;
						cmd.hist_waddr = {row, 2'd1};
						cmd.hist_wsel  = WS_HIST;
					end
					3'd3: begin
						cmd.hist_we    = 1'b1;
						cmd.hist_waddr = {row, 2'd3};
						cmd.hist_wsel  = WS_HIST;
					end
					3'd6: begin
						cmd.hist_we    = 1'b1;
						cmd.hist_waddr = {row, 2'd2};
						cmd.hist_wsel  = WS_Y;
						cmd.y_load     = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_GAIN: begin
				cmd.mul_en  = (ph_q == 3'd0);
				cmd.mul_sel = MS_GAIN;
				cmd.sum_en  = (ph_q == 3'd1);
			end
			S_OUT: begin
				cmd.out_load = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			n_q     <= '0;
			s_q     <= '0;
			ph_q    <= '0;
			clr_q   <= '0;
			ah_q    <= AH_W'(1);
			as_q    <= AS_W'(1);
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index)
					as_q <= cfg_data[AS_W-1:0];
				else
					ah_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + HIST_AW'(1);
					if (clr_q == CLR_LAST)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					n_q   <= '0;
					clr_q <= '0;
					unique case (sts.op)
						OP_CLEAR:   state_q <= S_CLEAR;
						OP_PROCESS: state_q <= (nh == '0) ? S_OUT : S_HARM;
						default:    state_q <= S_IDLE;
					endcase
				end
				S_HARM: begin
					s_q     <= '0;
					ph_q    <= '0;
					state_q <= (ns == '0) ? S_GAIN : S_STAGE;
				end
				S_STAGE: begin
					if (ph_q == 3'd6) begin
						ph_q <= '0;
						s_q  <= s_q + STAGE_FW'(1);
						if (last_s)
							state_q <= S_GAIN;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_GAIN: begin
					if (ph_q == 3'd1) begin
						ph_q <= '0;
						if (last_h) begin
							state_q <= S_OUT;
						end else begin
							n_q     <= n_q + HARM_W'(1);
							state_q <= S_HARM;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_OUT: begin
					if (!sts.out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_hist_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_we |-> (32'(cmd.hist_waddr) < CELLS))
		else $error("history write beyond memory");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result loaded over a waiting result");
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STAGE) |-> (32'(s_q) < MAX_STAGES))
		else $error("stage counter out of range");
	a_acc_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.y_load |-> $past(cmd.acc_en))
		else $error("stage output taken before accumulation finished");
`endif

endmodule

`default_nettype wire

// ===== rtl/harmonic_bandpass_biquad_bank.sv =====
// Bank of 64 harmonic chains of up to five bandpass biquads each, sharing one
// 24x24 multiplier. A process request runs, for each active harmonic, a setup
// step, each active stage and a gain step, then loads the result; each stage
// is seven steps of the single multiplier and the history memory, which has
// one read and one write port. A write request is performed in the decode
// state, a clear request sweeps the 1280-word history one word a cycle, and
// the same sweep runs after reset before the first request is taken. The result
// register lets a new request in while the previous result waits to be taken.
`default_nettype none

module harmonic_bandpass_biquad_bank import hbb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// harmonic[5:0], stage[8:6], coef_select[10:9], value[34:11], sample[50:35]
	input  wire logic [TDATA_W-1:0]   s_axis_tdata,
	// operation[1:0]
	input  wire logic [1:0]           s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// out_sample[23:0]
	output logic [COEF_WIDTH-1:0]     m_axis_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [AH_W-1:0]      cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic signed [COEF_WIDTH-1:0] out_data;

	hbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.cmd       (cmd)
	);

	hbb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = out_data;

endmodule

`default_nettype wire
